// ===== hdl/dtq_pkg.sv =====
// shared constants, codes and types of the delta timer queue
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DELAY_BITS  = 16;
    localparam int ID_BITS     = 8;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_BITS + DELAY_BITS;

    localparam int ID_FIELD_W    = 8;
    localparam int DELAY_FIELD_W = 16;
    localparam int OCC_FIELD_W   = 5;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_IGNORED   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_EXPIRED = 1'b1;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    typedef struct packed {
        alu_op_t               op;
        logic [DELAY_BITS-1:0] a;
        logic [DELAY_BITS-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [DELAY_BITS-1:0] res;
        logic                  borrow;
        logic                  zero;
    } alu_rsp_t;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [DELAY_BITS-1:0] delta;
    } entry_t;

endpackage

// ===== hdl/dtq_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/dtq_alu.sv =====
// shared add, subtract and zero test unit for delta arithmetic
`timescale 1ns / 1ps

module dtq_alu
    import dtq_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [DELAY_BITS:0]   diff;
    logic [DELAY_BITS-1:0] sum;

    assign diff = {1'b0, req.a} - {1'b0, req.b};
    assign sum  = req.a + req.b;

    always_comb begin
        rsp.res    = (req.op == ALU_ADD) ? sum : diff[DELAY_BITS-1:0];
        rsp.borrow = (req.op == ALU_SUB) && diff[DELAY_BITS];
        rsp.zero   = (rsp.res == '0);
    end

endmodule

// ===== hdl/delta_timer_queue_core.sv =====
// top level of the delta timer queue: request sequencer, entry store and result register
`timescale 1ns / 1ps

// Timed-wait queue kept as a delta list in a single-port-write RAM with registered read.
// One request is taken at a time; s_tready is low while it is worked. Insert and remove walk
// the list once between accept and acknowledgement, reading each entry and then using its
// data; an insert that lands before an existing entry also passes through S_FIX to adjust
// that entry's delta. A tick reads the head and any entries that expire with it, then moves
// the remaining entries down in the same way; a tick that expires nothing writes back the
// decremented head and is acknowledged. Zero delay, full queue, unknown request and a tick
// on an empty queue are acknowledged straight from idle. The walk is paced by the one RAM
// read per entry and the shared delta adder. Results go out through one output register, so
// a stalled result stream holds the sequencer only when a further result must be sent.
module delta_timer_queue_core
    import dtq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // thread_id[7:0], delay[23:8]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // expired_id[7:0], status[9:8], occupancy[14:10], zero[15]
    output logic        m_tuser,   // kind[0]
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_FIX,
        S_END,
        S_ACK
    } state_t;

    state_t                state_reg, state_next;
    logic [1:0]            req_reg, req_next;
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [DELAY_BITS-1:0] dly_reg, dly_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      lim_reg, lim_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic                  flag_reg, flag_next;
    entry_t                carry_reg, carry_next;
    logic [DELAY_BITS-1:0] acc_reg, acc_next;
    logic [ID_BITS-1:0]    hold_id_reg, hold_id_next;
    logic                  hold_v_reg, hold_v_next;
    logic [1:0]            status_reg, status_next;

    logic                  out_v_reg, out_v_next;
    logic                  out_kind_reg, out_kind_next;
    logic [ID_BITS-1:0]    out_id_reg, out_id_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [CNT_W-1:0]      out_occ_reg, out_occ_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_load;
    logic                  ld_kind;
    logic [ID_BITS-1:0]    ld_id;
    logic [1:0]            ld_status;
    logic [CNT_W-1:0]      ld_occ;
    logic                  ld_last;
    logic                  out_free;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    entry_t                ram_wdata;
    entry_t                rd_entry;

    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;

    logic [CNT_W-1:0]      idx_inc, idx_m1, idx_mk, cnt_m1;

    logic [ID_BITS+ID_FIELD_W-1:0]       id_wide;
    logic [DELAY_BITS+DELAY_FIELD_W-1:0] dly_wide;
    logic [ID_BITS-1:0]                  id_in;
    logic [DELAY_BITS-1:0]               dly_in;
    logic [1:0]                          req_in;
    logic [ID_FIELD_W+ID_BITS-1:0]       out_id_wide;
    logic [OCC_FIELD_W+CNT_W-1:0]        out_occ_wide;

    assign id_wide  = {{ID_BITS{1'b0}}, s_tdata[7:0]};
    assign dly_wide = {{DELAY_BITS{1'b0}}, s_tdata[23:8]};
    assign id_in    = id_wide[ID_BITS-1:0];
    assign dly_in   = dly_wide[DELAY_BITS-1:0];
    assign req_in   = s_tuser;

    assign idx_inc  = idx_reg + 1'b1;
    assign idx_m1   = idx_reg - 1'b1;
    assign idx_mk   = idx_reg - k_reg;
    assign cnt_m1   = cnt_reg - 1'b1;
    assign out_free = !out_v_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    dtq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    dtq_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        id_next      = id_reg;
        dly_next     = dly_reg;
        idx_next     = idx_reg;
        lim_next     = lim_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        flag_next    = flag_reg;
        carry_next   = carry_reg;
        acc_next     = acc_reg;
        hold_id_next = hold_id_reg;
        hold_v_next  = hold_v_reg;
        status_next  = status_reg;

        ram_we       = 1'b0;
        ram_waddr    = idx_reg[IDX_W-1:0];
        ram_wdata    = {id_reg, dly_reg};
        alu_req      = '{op: ALU_SUB, a: dly_reg, b: rd_entry.delta};

        out_load     = 1'b0;
        ld_kind      = KIND_ACK;
        ld_id        = '0;
        ld_status    = status_reg;
        ld_occ       = cnt_reg;
        ld_last      = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next    = req_in;
                    id_next     = id_in;
                    dly_next    = dly_in;
                    idx_next    = '0;
                    lim_next    = cnt_reg;
                    k_next      = '0;
                    flag_next   = 1'b0;
                    hold_v_next = 1'b0;
                    case (req_in)
                        REQ_INSERT: begin
                            if (dly_in == '0) begin
                                status_next = ST_IGNORED;
                                state_next  = S_ACK;
                            end else if (cnt_reg >= CNT_W'(QUEUE_DEPTH)) begin
                                status_next = ST_FULL;
                                state_next  = S_ACK;
                            end else begin
                                state_next  = S_RD;
                            end
                        end
                        REQ_REMOVE: begin
                            state_next = S_RD;
                        end
                        REQ_TICK: begin
                            if (cnt_reg == '0) begin
                                status_next = ST_OK;
                                state_next  = S_ACK;
                            end else begin
                                state_next  = S_RD;
                            end
                        end
                        default: begin
                            status_next = ST_IGNORED;
                            state_next  = S_ACK;
                        end
                    endcase
                end
            end
            S_RD: begin
                state_next = (idx_reg == lim_reg) ? S_END : S_EX;
            end
            S_EX: begin
                case (req_reg)
                    REQ_INSERT: begin
                        if (!flag_reg) begin
                            alu_req = '{op: ALU_SUB, a: dly_reg, b: rd_entry.delta};
                            if (!alu_rsp.borrow) begin
                                dly_next   = alu_rsp.res;
                                idx_next   = idx_inc;
                                state_next = S_RD;
                            end else begin
                                ram_we     = 1'b1;
                                ram_wdata  = {id_reg, dly_reg};
                                carry_next = rd_entry;
                                flag_next  = 1'b1;
                                state_next = S_FIX;
                            end
                        end else begin
                            ram_we     = 1'b1;
                            ram_wdata  = carry_reg;
                            carry_next = rd_entry;
                            idx_next   = idx_inc;
                            state_next = S_RD;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!flag_reg) begin
                            if (rd_entry.id == id_reg) begin
                                flag_next = 1'b1;
                                acc_next  = rd_entry.delta;
                            end
                        end else begin
                            alu_req   = '{op: ALU_ADD, a: rd_entry.delta, b: acc_reg};
                            ram_we    = 1'b1;
                            ram_waddr = idx_m1[IDX_W-1:0];
                            ram_wdata = {rd_entry.id, alu_rsp.res};
                            acc_next  = '0;
                        end
                        idx_next   = idx_inc;
                        state_next = S_RD;
                    end
                    REQ_TICK: begin
                        alu_req = '{op: ALU_SUB, a: rd_entry.delta,
                                    b: (idx_reg == '0) ? DELAY_BITS'(1) : '0};
                        if (!flag_reg && alu_rsp.zero) begin
                            if (!hold_v_reg || out_free) begin
                                if (hold_v_reg) begin
                                    out_load  = 1'b1;
                                    ld_kind   = KIND_EXPIRED;
                                    ld_id     = hold_id_reg;
                                    ld_status = ST_OK;
                                    ld_occ    = cnt_m1;
                                    ld_last   = 1'b0;
                                    cnt_next  = cnt_m1;
                                end
                                hold_id_next = rd_entry.id;
                                hold_v_next  = 1'b1;
                                k_next       = k_reg + 1'b1;
                                idx_next     = idx_inc;
                                state_next   = S_RD;
                            end
                        end else if (!flag_reg) begin
                            if (k_reg == '0) begin
                                ram_we      = 1'b1;
                                ram_wdata   = {rd_entry.id, alu_rsp.res};
                                status_next = ST_OK;
                                state_next  = S_ACK;
                            end else if (out_free) begin
                                out_load    = 1'b1;
                                ld_kind     = KIND_EXPIRED;
                                ld_id       = hold_id_reg;
                                ld_status   = ST_OK;
                                ld_occ      = cnt_m1;
                                ld_last     = 1'b1;
                                cnt_next    = cnt_m1;
                                hold_v_next = 1'b0;
                                flag_next   = 1'b1;
                                ram_we      = 1'b1;
                                ram_waddr   = idx_mk[IDX_W-1:0];
                                ram_wdata   = {rd_entry.id, alu_rsp.res};
                                idx_next    = idx_inc;
                                state_next  = S_RD;
                            end
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = idx_mk[IDX_W-1:0];
                            ram_wdata  = {rd_entry.id, alu_rsp.res};
                            idx_next   = idx_inc;
                            state_next = S_RD;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FIX: begin
                alu_req          = '{op: ALU_SUB, a: carry_reg.delta, b: dly_reg};
                carry_next.delta = alu_rsp.res;
                idx_next         = idx_inc;
                state_next       = S_RD;
            end
            S_END: begin
                case (req_reg)
                    REQ_INSERT: begin
                        ram_we      = 1'b1;
                        ram_wdata   = flag_reg ? carry_reg : entry_t'({id_reg, dly_reg});
                        cnt_next    = cnt_reg + 1'b1;
                        status_next = ST_OK;
                        state_next  = S_ACK;
                    end
                    REQ_REMOVE: begin
                        if (flag_reg) begin
                            cnt_next    = cnt_m1;
                            status_next = ST_OK;
                        end else begin
                            status_next = ST_NOT_FOUND;
                        end
                        state_next = S_ACK;
                    end
                    REQ_TICK: begin
                        if (!hold_v_reg) begin
                            state_next = S_IDLE;
                        end else if (out_free) begin
                            out_load    = 1'b1;
                            ld_kind     = KIND_EXPIRED;
                            ld_id       = hold_id_reg;
                            ld_status   = ST_OK;
                            ld_occ      = cnt_m1;
                            ld_last     = 1'b1;
                            cnt_next    = cnt_m1;
                            hold_v_next = 1'b0;
                            state_next  = S_IDLE;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ACK: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_v_next      = out_v_reg;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;
        out_last_next   = out_last_reg;
        if (out_load) begin
            out_v_next      = 1'b1;
            out_kind_next   = ld_kind;
            out_id_next     = ld_id;
            out_status_next = ld_status;
            out_occ_next    = ld_occ;
            out_last_next   = ld_last;
        end else if (m_tready) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            out_v_reg  <= 1'b0;
            hold_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            out_v_reg  <= out_v_next;
            hold_v_reg <= hold_v_next;
        end
        req_reg        <= req_next;
        id_reg         <= id_next;
        dly_reg        <= dly_next;
        idx_reg        <= idx_next;
        lim_reg        <= lim_next;
        k_reg          <= k_next;
        flag_reg       <= flag_next;
        carry_reg      <= carry_next;
        acc_reg        <= acc_next;
        hold_id_reg    <= hold_id_next;
        status_reg     <= status_next;
        out_kind_reg   <= out_kind_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
        out_occ_reg    <= out_occ_next;
        out_last_reg   <= out_last_next;
    end

    assign out_id_wide  = {{ID_FIELD_W{1'b0}}, out_id_reg};
    assign out_occ_wide = {{OCC_FIELD_W{1'b0}}, out_occ_reg};

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_occ_wide[OCC_FIELD_W-1:0], out_status_reg,
                       out_id_wide[ID_FIELD_W-1:0]};

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_v_reg || m_tready))
        else $error("result register overwritten while a result waits");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_EXPIRED)) |-> (m_tdata[9:8] == ST_OK))
        else $error("expired notice with nonzero status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EX && req_reg == REQ_TICK && !flag_reg && !alu_rsp.zero
         && k_reg != '0) |-> hold_v_reg)
        else $error("expiry run ended without a held notice");

endmodule
